FILE: design/multi_waveform_oscillator_assert.svh
// assertion shorthands, clocked on clk_i and quiet while rst_ni is low
`ifndef MULTI_WAVEFORM_OSCILLATOR_ASSERT_SVH
`define MULTI_WAVEFORM_OSCILLATOR_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define MWO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define MWO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/mwo_pkg.sv
package mwo_pkg;

  // wave tables
  localparam int unsigned TAB_DEPTH = 512;
  localparam int unsigned TAB_AW    = $clog2(TAB_DEPTH);
  localparam int unsigned QUART     = TAB_DEPTH / 4;
  localparam int unsigned QW        = TAB_AW - 2;
  localparam int unsigned FRAC_W    = 32 - TAB_AW;
  localparam int unsigned TRI_SH    = 17 - TAB_AW;

  localparam int unsigned MAX_BUF = 4096;
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned ADDR_W  = 5;

  // waveform codes
  localparam logic [2:0] WF_SAW     = 3'd0;
  localparam logic [2:0] WF_SQUARE  = 3'd1;
  localparam logic [2:0] WF_NOISE   = 3'd2;
  localparam logic [2:0] WF_TRI     = 3'd3;
  localparam logic [2:0] WF_INTERP  = 3'd4;
  localparam logic [2:0] WF_TTRI    = 3'd5;
  localparam logic [2:0] WF_TSINE   = 3'd6;
  localparam logic [2:0] WF_INVALID = 3'd7;

  // register indexes
  localparam logic [2:0] REG_WAVEFORM = 3'd0;
  localparam logic [2:0] REG_STEP     = 3'd1;
  localparam logic [2:0] REG_PW       = 3'd2;
  localparam logic [2:0] REG_TARGET   = 3'd3;
  localparam logic [2:0] REG_BUFLEN   = 3'd4;

  localparam logic signed [34:0] ONE_Q28   = 35'sd268435456;
  localparam logic [28:0]        STEP_MAX  = 29'd510027366;
  localparam logic signed [28:0] PW_MAX    = 29'sd241591910;
  localparam logic [14:0]        AMP_FLOOR = 15'd33;
  localparam logic signed [32:0] AMP_TOP   = 33'sd1073709056;
  localparam logic [30:0]        PM_MOD    = 31'h7fffffff;
  localparam logic [14:0]        PM_MULT   = 15'd16807;

  localparam logic [2:0]  RST_WAVEFORM = WF_SAW;
  localparam logic [28:0] RST_STEP     = 29'd2678268;
  localparam logic [12:0] RST_BUFLEN   = 13'd1024;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint Q30_L       = 64'sd1073741824;

  typedef enum logic [1:0] {MS_ILO, MS_IHI, MS_SEED, MS_AMP} mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     silent_upd;
    logic     rdiv_start;
    logic     rinc_load;
    logic     wdiv_start;
    logic     tab_adv;
    logic     rom0;
    logic     rom1;
    logic     acc_ld;
    logic     val_ld;
    logic     seed_upd;
    logic     mul_en;
    logic     finish;
    mul_sel_e mul_sel;
  } cmd_t;

  typedef struct packed {
    logic       fob;
    logic       silent_new;
    logic       mute;
    logic       wrap;
    logic [2:0] waveform;
    logic       div_busy;
  } stat_t;

  typedef struct packed {
    logic [2:0]         waveform;
    logic [28:0]        phase_step;
    logic signed [28:0] pulse_width;
    logic [14:0]        target_amp;
    logic [12:0]        buf_len;
    logic               wf_clear;
  } cfg_t;

  // quarter sine, Q1.15 magnitudes, worked out at elaboration
  function automatic logic [(QUART+1)*17-1:0] build_qsine();
    logic [(QUART+1)*17-1:0] tab;
    longint r, x, x2, t, s;
    int k;
    tab = '0;
    for (k = 0; k <= int'(QUART); k++) begin
      r  = (longint'(k) * Q30_L) / QUART;
      x  = (r * HALF_PI_Q30) >>> 30;
      x2 = (x * x) >>> 30;
      t  = Q30_L - x2 / 72;
      t  = Q30_L - ((x2 * t) >>> 30) / 42;
      t  = Q30_L - ((x2 * t) >>> 30) / 20;
      t  = Q30_L - ((x2 * t) >>> 30) / 6;
      s  = (x * t) >>> 30;
      s  = (s + 64'sd16384) >>> 15;
      tab[k*17 +: 17] = s[16:0];
    end
    return tab;
  endfunction

  localparam logic [(QUART+1)*17-1:0] QSINE = build_qsine();

  // full table entry 0..TAB_DEPTH, sine or triangle
  function automatic logic signed [16:0] rom_val(input logic is_tri,
                                                 input logic [TAB_AW:0] c);
    logic [1:0]          quad;
    logic [QW:0]         k;
    logic signed [16:0]  q;
    logic signed [17:0]  ramp;
    logic signed [17:0]  tv;
    quad = c[TAB_AW-1 -: 2];
    k    = quad[0] ? ((QW+1)'(QUART) - {1'b0, c[QW-1:0]}) : {1'b0, c[QW-1:0]};
    q    = $signed(QSINE[int'(k)*17 +: 17]);
    ramp = $signed({{(TRI_SH+1){1'b0}}, c[TAB_AW-2:0]} << TRI_SH);
    if (c[TAB_AW]) begin
      tv = -18'sd32768;
    end else if (c[TAB_AW-1]) begin
      tv = 18'sd32768 - ramp;
    end else begin
      tv = -18'sd32768 + ramp;
    end
    if (is_tri) begin
      return tv[16:0];
    end
    return quad[1] ? -q : q;
  endfunction

  function automatic logic signed [15:0] clamp16(input logic signed [66:0] v);
    if (v > 67'sd32767) begin
      return 16'sd32767;
    end else if (v < -67'sd32768) begin
      return $signed(16'h8000);
    end
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sh07fffffff) begin
      return 32'sh7fffffff;
    end else if (v < -36'sh080000000) begin
      return $signed(32'h80000000);
    end
    return v[31:0];
  endfunction

endpackage

FILE: design/mwo_div.sv
module mwo_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [29:0] rem_i,
  input  logic [31:0] quo_i,
  input  logic [28:0] den_i,
  input  logic [5:0]  iters_i,
  output logic        busy_o,
  output logic [31:0] quo_o
);
  import mwo_pkg::*;

  logic [29:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [28:0] den_q;
  logic [5:0]  cnt_q, cnt_d;
  logic [30:0] trial, diff;
  logic        ge;

  // restoring, one quotient bit a cycle
  assign trial = {rem_q, quo_q[31]};
  assign ge    = trial >= {2'b0, den_q};
  assign diff  = trial - {2'b0, den_q};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = rem_i;
      quo_d = quo_i;
      cnt_d = iters_i;
    end else if (cnt_q != 6'd0) begin
      rem_d = ge ? diff[29:0] : trial[29:0];
      quo_d = {quo_q[30:0], ge};
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 6'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = cnt_q != 6'd0;
  assign quo_o  = quo_q;

endmodule

FILE: design/mwo_ctrl.sv
module mwo_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  mwo_pkg::stat_t stat_i,
  output mwo_pkg::cmd_t  cmd_o
);
  import mwo_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RAMP = 4'd1;
  localparam logic [3:0] ST_RDIV = 4'd2;
  localparam logic [3:0] ST_SEL  = 4'd3;
  localparam logic [3:0] ST_WDIV = 4'd4;
  localparam logic [3:0] ST_TAB0 = 4'd5;
  localparam logic [3:0] ST_TAB1 = 4'd6;
  localparam logic [3:0] ST_IA   = 4'd7;
  localparam logic [3:0] ST_IB   = 4'd8;
  localparam logic [3:0] ST_IC   = 4'd9;
  localparam logic [3:0] ST_NS   = 4'd10;
  localparam logic [3:0] ST_NM   = 4'd11;
  localparam logic [3:0] ST_MUL  = 4'd12;
  localparam logic [3:0] ST_FIN  = 4'd13;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o   = '0;
    cmd_o.mul_sel = MS_AMP;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RAMP;
        end
      end
      ST_RAMP: begin
        if (stat_i.fob) begin
          cmd_o.silent_upd = 1'b1;
          if (!stat_i.silent_new) begin
            cmd_o.rdiv_start = 1'b1;
            state_d          = ST_RDIV;
          end else begin
            state_d = ST_SEL;
          end
        end else begin
          state_d = ST_SEL;
        end
      end
      ST_RDIV: begin
        if (!stat_i.div_busy) begin
          cmd_o.rinc_load = 1'b1;
          state_d         = ST_SEL;
        end
      end
      ST_SEL: begin
        if (stat_i.mute) begin
          state_d = ST_FIN;
        end else begin
          case (stat_i.waveform) inside
            WF_SAW, WF_SQUARE: begin
              if (stat_i.wrap) begin
                cmd_o.wdiv_start = 1'b1;
                state_d          = ST_WDIV;
              end else begin
                state_d = ST_MUL;
              end
            end
            WF_NOISE: state_d = stat_i.wrap ? ST_NS : ST_MUL;
            WF_TRI:   state_d = ST_MUL;
            default: begin
              cmd_o.tab_adv = 1'b1;
              state_d       = ST_TAB0;
            end
          endcase
        end
      end
      ST_WDIV: begin
        if (!stat_i.div_busy) begin
          state_d = ST_MUL;
        end
      end
      ST_TAB0: begin
        cmd_o.rom0 = 1'b1;
        state_d    = (stat_i.waveform == WF_INTERP) ? ST_TAB1 : ST_MUL;
      end
      ST_TAB1: begin
        cmd_o.rom1 = 1'b1;
        state_d    = ST_IA;
      end
      ST_IA: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_ILO;
        state_d       = ST_IB;
      end
      ST_IB: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_IHI;
        cmd_o.acc_ld  = 1'b1;
        state_d       = ST_IC;
      end
      ST_IC: begin
        cmd_o.val_ld = 1'b1;
        state_d      = ST_MUL;
      end
      ST_NS: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_SEED;
        state_d       = ST_NM;
      end
      ST_NM: begin
        cmd_o.seed_upd = 1'b1;
        state_d        = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q && out_stall_i) || cmd_o.finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: design/mwo_dp.sv
module mwo_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mwo_pkg::cfg_t      cfg_i,
  input  mwo_pkg::cmd_t      cmd_i,
  input  logic               first_of_buffer_i,
  input  logic               snap_amplitude_i,
  output mwo_pkg::stat_t     stat_o,
  output logic signed [15:0] sample_o,
  output logic               active_o
);
  import mwo_pkg::*;

  logic signed [31:0] saw_q, tri_q, amp_q, inc_q;
  logic [31:0]        tab_q;
  logic               low_q, silent_q, fob_q, wsat_q, rneg_q;
  logic signed [15:0] held_q;
  logic [30:0]        seed_q;
  logic signed [16:0] v0_q, v1_q, val_q;
  logic signed [66:0] prod_q, acc_q;
  logic signed [15:0] sample_q;
  logic               active_q;

  logic [LEN_W-1:0]   len;
  logic               silent_new, mute, wrap;
  logic signed [31:0] num;
  logic               num_ge;
  logic signed [32:0] tgt33, amp33, inc33, diff, diff_neg, amp_sum;
  logic [31:0]        mag, quo, amp_next;
  logic               div_start, div_busy;
  logic [28:0]        d_val;
  logic signed [34:0] saw35, tri35, step35, pw35, d35, one_m_2d, tri_abs, opnd;
  logic signed [34:0] saw_adj, tri_sum, tri_adj;
  logic signed [31:0] mul_a;
  logic signed [34:0] mul_b;
  logic signed [66:0] product;
  logic [31:0]        pm_sum, pm_red;
  logic signed [15:0] noise_new, amp15, s_fin;
  logic [TAB_AW-1:0]  idx;
  logic [FRAC_W-1:0]  frac;
  logic signed [66:0] isum;

  assign len = (cfg_i.buf_len == '0) ? LEN_W'(1) :
               (cfg_i.buf_len > LEN_W'(MAX_BUF)) ? LEN_W'(MAX_BUF) : cfg_i.buf_len;

  assign silent_new = (cfg_i.target_amp < AMP_FLOOR) || (cfg_i.waveform == WF_INVALID);
  assign mute       = silent_q || (cfg_i.waveform == WF_INVALID);

  assign saw35  = {{3{saw_q[31]}}, saw_q};
  assign tri35  = {{3{tri_q[31]}}, tri_q};
  assign step35 = $signed({6'b0, cfg_i.phase_step});
  assign pw35   = {{6{cfg_i.pulse_width[28]}}, cfg_i.pulse_width};
  assign wrap   = (cfg_i.waveform <= WF_NOISE) && (saw35 >= ONE_Q28);

  // wrap fraction: overshoot past 1.0 over the step
  assign num    = saw_q - 32'sd268435456;
  assign num_ge = $unsigned(num) >= {3'b0, cfg_i.phase_step};

  // ramp slope dividend, magnitude and sign
  assign tgt33    = $signed({3'b0, cfg_i.target_amp, 15'b0});
  assign amp33    = {amp_q[31], amp_q};
  assign inc33    = {inc_q[31], inc_q};
  assign diff     = tgt33 - amp33;
  assign diff_neg = -diff;
  assign mag      = diff[32] ? diff_neg[31:0] : diff[31:0];

  assign div_start = cmd_i.rdiv_start || (cmd_i.wdiv_start && !num_ge);

  mwo_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (cmd_i.rdiv_start ? 30'd0 : num[29:0]),
    .quo_i   (cmd_i.rdiv_start ? mag : 32'd0),
    .den_i   (cmd_i.rdiv_start ? {{(29-LEN_W){1'b0}}, len} : cfg_i.phase_step),
    .iters_i (cmd_i.rdiv_start ? 6'd32 : 6'd28),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  assign d_val    = wsat_q ? 29'h1000_0000 : {1'b0, quo[27:0]};
  assign d35      = $signed({6'b0, d_val});
  assign one_m_2d = ONE_Q28 - (d35 <<< 1);
  assign tri_abs  = tri_q[31] ? -tri35 : tri35;

  // table position
  assign idx  = tab_q[31 -: TAB_AW];
  assign frac = tab_q[FRAC_W-1:0];

  always_comb begin
    case (cfg_i.waveform) inside
      WF_SAW:    opnd = wrap ? one_m_2d : saw35;
      WF_SQUARE: opnd = low_q ? -one_m_2d : one_m_2d;
      WF_NOISE:  opnd = $signed({4'b0, seed_q}) - 35'sd1073741824;
      WF_TRI:    opnd = ONE_Q28 - (tri_abs <<< 1);
      WF_INTERP: opnd = {{18{val_q[16]}}, val_q};
      default:   opnd = {{18{v0_q[16]}}, v0_q};
    endcase
  end

  // shared multiplier
  always_comb begin
    case (cmd_i.mul_sel)
      MS_ILO: begin
        mul_a = {{15{v0_q[16]}}, v0_q};
        mul_b = $signed(35'(({1'b1, {FRAC_W{1'b0}}}) - {1'b0, frac}));
      end
      MS_IHI: begin
        mul_a = {{15{v1_q[16]}}, v1_q};
        mul_b = $signed({{(35-FRAC_W){1'b0}}, frac});
      end
      MS_SEED: begin
        mul_a = $signed({17'b0, PM_MULT});
        mul_b = $signed({4'b0, seed_q});
      end
      default: begin
        mul_a = amp_q;
        mul_b = opnd;
      end
    endcase
  end

  assign product = mul_a * mul_b;
  assign isum    = (acc_q + prod_q) >>> FRAC_W;

  // park-miller step: fold the product modulo 2^31-1
  assign pm_sum = {17'b0, prod_q[45:31]} + {1'b0, prod_q[30:0]};
  assign pm_red = (pm_sum >= {1'b0, PM_MOD}) ? (pm_sum - {1'b0, PM_MOD}) : pm_sum;

  assign noise_new = clamp16(prod_q >>> 45);
  assign amp15     = amp_q[30:15];

  always_comb begin
    case (cfg_i.waveform) inside
      WF_SAW, WF_TRI: s_fin = clamp16(prod_q >>> 43);
      WF_SQUARE: begin
        if (wrap) begin
          s_fin = clamp16(prod_q >>> 43);
        end else begin
          s_fin = low_q ? -amp15 : amp15;
        end
      end
      WF_NOISE: s_fin = wrap ? noise_new : held_q;
      default:  s_fin = clamp16(prod_q >>> 30);
    endcase
  end

  always_comb begin
    saw_adj = saw35;
    if (wrap) begin
      if (cfg_i.waveform == WF_SQUARE) begin
        saw_adj = saw35 - ONE_Q28 + (low_q ? -pw35 : pw35);
      end else begin
        saw_adj = saw35 - (ONE_Q28 <<< 1);
      end
    end
  end

  assign tri_sum = tri35 + step35;
  assign tri_adj = (tri_sum > ONE_Q28) ? (tri_sum - (ONE_Q28 <<< 1)) : tri_sum;

  assign amp_sum  = amp33 + inc33;
  assign amp_next = (amp_sum < 33'sd0) ? 32'd0 :
                    (amp_sum > AMP_TOP) ? AMP_TOP[31:0] : amp_sum[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saw_q    <= '0;
      tri_q    <= '0;
      tab_q    <= '0;
      low_q    <= 1'b0;
      held_q   <= '0;
      seed_q   <= 31'd1;
      amp_q    <= '0;
      inc_q    <= '0;
      silent_q <= 1'b0;
      fob_q    <= 1'b0;
      wsat_q   <= 1'b0;
      rneg_q   <= 1'b0;
    end else begin
      if (cfg_i.wf_clear) begin
        if (saw35 > ONE_Q28) begin
          saw_q <= '0;
        end
        if (tri35 > ONE_Q28) begin
          tri_q <= '0;
        end
      end
      if (cmd_i.load) begin
        fob_q <= first_of_buffer_i;
        if (snap_amplitude_i) begin
          amp_q <= tgt33[31:0];
        end
      end
      if (cmd_i.silent_upd) begin
        silent_q <= silent_new;
      end
      if (cmd_i.rdiv_start) begin
        rneg_q <= diff[32];
      end
      if (cmd_i.rinc_load) begin
        inc_q <= rneg_q ? -$signed(quo) : $signed(quo);
      end
      if (cmd_i.wdiv_start) begin
        wsat_q <= num_ge;
      end
      if (cmd_i.tab_adv) begin
        tab_q <= tab_q + {cfg_i.phase_step, 3'b0};
      end
      if (cmd_i.seed_upd) begin
        seed_q <= pm_red[30:0];
      end
      if (cmd_i.finish && !mute) begin
        amp_q <= amp_next;
        if (cfg_i.waveform <= WF_NOISE) begin
          saw_q <= sat32({saw_adj[34], saw_adj} + {step35[34], step35});
        end
        if (cfg_i.waveform == WF_SQUARE && wrap) begin
          low_q <= !low_q;
        end
        if (cfg_i.waveform == WF_NOISE && wrap) begin
          held_q <= noise_new;
        end
        if (cfg_i.waveform == WF_TRI) begin
          tri_q <= sat32({tri_adj[34], tri_adj});
        end
      end
    end
  end

  // working registers and output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.rom0) begin
      v0_q <= rom_val(cfg_i.waveform == WF_TTRI, {1'b0, idx});
    end
    if (cmd_i.rom1) begin
      v1_q <= rom_val(1'b0, {1'b0, idx} + (TAB_AW+1)'(1));
    end
    if (cmd_i.mul_en) begin
      prod_q <= product;
    end
    if (cmd_i.acc_ld) begin
      acc_q <= prod_q;
    end
    if (cmd_i.val_ld) begin
      val_q <= isum[16:0];
    end
    if (cmd_i.finish) begin
      sample_q <= mute ? 16'sd0 : s_fin;
      active_q <= !mute;
    end
  end

  assign stat_o.fob        = fob_q;
  assign stat_o.silent_new = silent_new;
  assign stat_o.mute       = mute;
  assign stat_o.wrap       = wrap;
  assign stat_o.waveform   = cfg_i.waveform;
  assign stat_o.div_busy   = div_busy;

  assign sample_o = sample_q;
  assign active_o = active_q;

endmodule

FILE: design/multi_waveform_oscillator.sv
// multi-waveform oscillator: each accepted word is one sample tick and
// yields one Q1.15 output word of the waveform selected in the waveform
// register (saw, square, sample-and-hold noise, triangle, interpolated
// sine, table triangle, table sine), scaled by an amplitude that ramps
// linearly over a buffer towards target_amp. One shared restoring divider
// that makes one quotient bit a cycle sets most of a tick's length: the
// ramp slope on the first tick of a buffer and the wrap fraction of saw
// and square; the shared multiplier forms products one at a time, more
// of them for the interpolated sine. The next tick is taken once the
// current one is handed to the output register, which holds a finished
// word while the sink stalls. Configuration is written over the APB port
// while idle, a user's rule the block itself does not enforce; registers
// sit at byte addresses 0,4,8,12,16 in the order waveform, phase_step,
// pulse_width, target_amp, buffer_length
module multi_waveform_oscillator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // tick channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        first_of_buffer_i,
  input  logic                        snap_amplitude_i,
  // sample channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [15:0]          sample_o,
  output logic                        active_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mwo_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import mwo_pkg::*;

  logic [2:0]         waveform_q;
  logic [28:0]        step_q;
  logic signed [28:0] pw_q;
  logic [14:0]        target_q;
  logic [12:0]        buflen_q;
  logic               wr;
  logic [2:0]         reg_idx;
  logic [28:0]        step_wr;
  logic signed [28:0] pw_wr;
  cfg_t               cfg;
  cmd_t               cmd;
  stat_t              stat;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  // write-side clamps
  assign step_wr = (pwdata[28:0] > STEP_MAX) ? STEP_MAX : pwdata[28:0];
  assign pw_wr   = ($signed(pwdata[28:0]) > PW_MAX) ? PW_MAX :
                   ($signed(pwdata[28:0]) < -PW_MAX) ? -PW_MAX : $signed(pwdata[28:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q <= RST_WAVEFORM;
      step_q     <= RST_STEP;
      pw_q       <= '0;
      target_q   <= '0;
      buflen_q   <= RST_BUFLEN;
    end else if (wr) begin
      unique case (reg_idx)
        REG_WAVEFORM: waveform_q <= pwdata[2:0];
        REG_STEP:     step_q     <= step_wr;
        REG_PW:       pw_q       <= pw_wr;
        REG_TARGET:   target_q   <= pwdata[14:0];
        REG_BUFLEN:   buflen_q   <= pwdata[12:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WAVEFORM: prdata = {29'b0, waveform_q};
      REG_STEP:     prdata = {3'b0, step_q};
      REG_PW:       prdata = {{3{pw_q[28]}}, pw_q};
      REG_TARGET:   prdata = {17'b0, target_q};
      REG_BUFLEN:   prdata = {19'b0, buflen_q};
      default:      prdata = 32'd0;
    endcase
  end

  // a change of waveform drops any phase left above 1.0
  assign cfg.waveform    = waveform_q;
  assign cfg.phase_step  = step_q;
  assign cfg.pulse_width = pw_q;
  assign cfg.target_amp  = target_q;
  assign cfg.buf_len     = buflen_q;
  assign cfg.wf_clear    = wr && (reg_idx == REG_WAVEFORM) && (pwdata[2:0] != waveform_q);

  mwo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mwo_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .cmd_i             (cmd),
    .first_of_buffer_i (first_of_buffer_i),
    .snap_amplitude_i  (snap_amplitude_i),
    .stat_o            (stat),
    .sample_o          (sample_o),
    .active_o          (active_o)
  );

endmodule

FILE: design/mwo_checker.sv
`include "multi_waveform_oscillator_assert.svh"

module mwo_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] sample_o,
  input logic               active_o
);

  // a stalled word holds
  `MWO_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(sample_o) && $stable(active_o), "stalled output word changed")

  // a silent word carries a zero sample
  `MWO_ASSERT_IMP(a_silent_zero, out_valid_o && !active_o, sample_o == 16'sd0, "silent word with nonzero sample")

  // one tick at a time: busy right after a word is taken
  `MWO_ASSERT_NXT(a_busy_after_take, in_valid_i && !in_stall_o, in_stall_o, "input taken while a tick is in flight")

endmodule

bind multi_waveform_oscillator mwo_checker u_mwo_checker (.*);
